/* hdl/complex_arithmetic_unit_defines.svh */
// Assertion macros shared by the complex arithmetic unit modules.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked at every edge outside reset.
`define CAU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
// Consequent checked in the cycle after the antecedent.
`define CAU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) \
      else $error("%m: check failed");
`else
`define CAU_ASSERT(lbl, clk, rst, prop)
`define CAU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hdl/cau_pkg.sv */
// Types and constants of the complex arithmetic unit.
package cau_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   localparam int PROD_W     = 2 * DATA_WIDTH;          // product, squared magnitude
   localparam int SUM_W      = PROD_W + 1;              // signed sum of two products
   localparam int QUOT_W     = DATA_WIDTH + 1;          // quotient bits developed
   localparam int NUM_W      = PROD_W + FRAC_BITS;      // scaled dividend
   localparam int HEAD_W     = NUM_W - QUOT_W;          // dividend bits above the quotient
   localparam int REM_W      = (HEAD_W > PROD_W) ? HEAD_W : PROD_W;
   localparam int DIV_STAGES = QUOT_W;

   localparam int QUEUE_DEPTH = 2;                      // power of two, pointers wrap
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int ACTION_W   = 4;
   localparam int REQ_DATA_W = ((4 * DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_USER_W = 3;

   typedef logic signed [DATA_WIDTH-1:0] word_type;
   typedef logic [ACTION_W-1:0]          action_type;

   localparam word_type WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   localparam action_type ACT_ADD = 4'd0;
   localparam action_type ACT_SUB = 4'd1;
   localparam action_type ACT_MUL = 4'd2;
   localparam action_type ACT_DIV = 4'd3;
   localparam action_type ACT_EQ  = 4'd4;
   localparam action_type ACT_NE  = 4'd5;
   localparam action_type ACT_LT  = 4'd6;
   localparam action_type ACT_GT  = 4'd7;
   localparam action_type ACT_LE  = 4'd8;
   localparam action_type ACT_GE  = 4'd9;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_ADD,
      KIND_SUB,
      KIND_MUL,
      KIND_DIV,
      KIND_TRUTH,
      KIND_MAG
   } kind_type;

   typedef enum logic [1:0] {
      REL_LT,
      REL_GT,
      REL_LE,
      REL_GE
   } rel_type;

   // Classified item handed from front to back.
   typedef struct packed {
      kind_type kind;
      rel_type  rel;
      logic     truth;
      word_type a_real;
      word_type a_imag;
      word_type b_real;
      word_type b_imag;
   } item_type;

   // One result beat.
   typedef struct packed {
      word_type re;
      word_type im;
      logic     truth;
      logic     zdiv;
      logic     ovf;
   } res_type;

endpackage

/* hdl/cau_front.sv */
// Front end: input register and action decode.
module cau_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  cau_pkg::action_type  req_action,
   input  cau_pkg::word_type    req_a_real,
   input  cau_pkg::word_type    req_a_imag,
   input  cau_pkg::word_type    req_b_real,
   input  cau_pkg::word_type    req_b_imag,
   output logic                 item_valid,
   input  logic                 item_ready,
   output cau_pkg::item_type    item
);

   logic              valid_ff, valid_in;
   cau_pkg::item_type item_ff, item_in;
   logic              take;

   assign req_tready = !valid_ff || item_ready;
   assign take       = req_tvalid && req_tready;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      item_in        = '0;
      item_in.kind   = cau_pkg::KIND_NONE;
      item_in.rel    = cau_pkg::REL_LT;
      item_in.a_real = req_a_real;
      item_in.a_imag = req_a_imag;
      item_in.b_real = req_b_real;
      item_in.b_imag = req_b_imag;
      case (req_action)
         cau_pkg::ACT_ADD: item_in.kind = cau_pkg::KIND_ADD;
         cau_pkg::ACT_SUB: item_in.kind = cau_pkg::KIND_SUB;
         cau_pkg::ACT_MUL: item_in.kind = cau_pkg::KIND_MUL;
         cau_pkg::ACT_DIV: item_in.kind = cau_pkg::KIND_DIV;
         cau_pkg::ACT_EQ: begin
            item_in.kind  = cau_pkg::KIND_TRUTH;
            item_in.truth = (req_a_real == req_b_real) && (req_a_imag == req_b_imag);
         end
         cau_pkg::ACT_NE: begin
            item_in.kind  = cau_pkg::KIND_TRUTH;
            item_in.truth = (req_a_real != req_b_real) || (req_a_imag != req_b_imag);
         end
         cau_pkg::ACT_LT: begin
            item_in.kind = cau_pkg::KIND_MAG;
            item_in.rel  = cau_pkg::REL_LT;
         end
         cau_pkg::ACT_GT: begin
            item_in.kind = cau_pkg::KIND_MAG;
            item_in.rel  = cau_pkg::REL_GT;
         end
         cau_pkg::ACT_LE: begin
            item_in.kind = cau_pkg::KIND_MAG;
            item_in.rel  = cau_pkg::REL_LE;
         end
         cau_pkg::ACT_GE: begin
            item_in.kind = cau_pkg::KIND_MAG;
            item_in.rel  = cau_pkg::REL_GE;
         end
         default: item_in.kind = cau_pkg::KIND_NONE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

/* hdl/cau_queue.sv */
// Two-entry queue between front and back.
`include "complex_arithmetic_unit_defines.svh"
module cau_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  cau_pkg::item_type  in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output cau_pkg::item_type  out_item
);

   cau_pkg::item_type           entries_ff [cau_pkg::QUEUE_DEPTH];
   logic [cau_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [cau_pkg::QCNT_W-1:0]  count_ff, count_in;
   logic                        push, pop;

   assign in_ready  = count_ff != cau_pkg::QCNT_W'(cau_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_item;
      end
   end

   `CAU_ASSERT(a_q_bound, clock, reset, count_ff <= cau_pkg::QCNT_W'(cau_pkg::QUEUE_DEPTH))
   `CAU_ASSERT_NEXT(a_q_fill, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `CAU_ASSERT_NEXT(a_q_drain, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1)

endmodule

/* hdl/cau_back.sv */
// Back end: multiply, sum, magnitude, pipelined restoring divide, saturate.
`include "complex_arithmetic_unit_defines.svh"
module cau_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_ready,
   input  cau_pkg::item_type  item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output cau_pkg::res_type   rsp_res
);

   typedef logic signed [cau_pkg::PROD_W-1:0]     prod_type;
   typedef logic [cau_pkg::PROD_W-1:0]            umag_type;
   typedef logic signed [cau_pkg::SUM_W-1:0]      sum_type;
   typedef logic [cau_pkg::SUM_W-1:0]             abs_type;
   typedef logic [cau_pkg::NUM_W-1:0]             num_type;
   typedef logic [cau_pkg::REM_W-1:0]             rem_type;
   typedef logic [cau_pkg::QUOT_W-1:0]            quot_type;
   typedef logic signed [cau_pkg::DATA_WIDTH:0]   wide_word_type;

   typedef struct packed {
      cau_pkg::word_type value;
      logic              ovf;
   } sat_type;

   typedef struct packed {
      cau_pkg::kind_type kind;
      cau_pkg::res_type  res;
      logic              neg_re;
      logic              neg_im;
      logic              head_re;
      logic              head_im;
      umag_type          d;
   } carry_type;

   function automatic sat_type sat_mag(input logic neg, input abs_type mag);
      abs_type lim;
      sat_type r;
      lim = abs_type'(1) << (cau_pkg::DATA_WIDTH - 1);
      if (!neg) begin
         lim = lim - abs_type'(1);
      end
      if (mag > lim) begin
         r.ovf   = 1'b1;
         r.value = neg ? cau_pkg::WORD_MIN : cau_pkg::WORD_MAX;
      end else begin
         r.ovf   = 1'b0;
         r.value = neg ? -cau_pkg::word_type'(mag[cau_pkg::DATA_WIDTH-1:0])
                       : cau_pkg::word_type'(mag[cau_pkg::DATA_WIDTH-1:0]);
      end
      return r;
   endfunction

   function automatic sat_type sat_sum(input wide_word_type v);
      sat_type r;
      r.ovf = v[cau_pkg::DATA_WIDTH] ^ v[cau_pkg::DATA_WIDTH-1];
      if (r.ovf) begin
         r.value = v[cau_pkg::DATA_WIDTH] ? cau_pkg::WORD_MIN : cau_pkg::WORD_MAX;
      end else begin
         r.value = v[cau_pkg::DATA_WIDTH-1:0];
      end
      return r;
   endfunction

   logic advance;

   // stage 1: products, add/sub, truths from the front
   logic              s1_valid_ff;
   cau_pkg::kind_type s1_kind_ff;
   cau_pkg::rel_type  s1_rel_ff;
   cau_pkg::res_type  s1_res_ff, s1_res_in;
   prod_type          s1_rr_ff, s1_ii_ff, s1_ri_ff, s1_ir_ff;
   prod_type          s1_sar_ff, s1_sai_ff, s1_sbr_ff, s1_sbi_ff;

   // stage 2: sums of products
   logic              s2_valid_ff;
   cau_pkg::kind_type s2_kind_ff;
   cau_pkg::rel_type  s2_rel_ff;
   cau_pkg::res_type  s2_res_ff;
   sum_type           s2_re_ff, s2_re_in, s2_im_ff, s2_im_in;
   umag_type          s2_ma_ff, s2_mb_ff;

   // stage 3: sign and magnitude, compare, zero divisor
   logic              s3_valid_ff;
   cau_pkg::kind_type s3_kind_ff;
   cau_pkg::res_type  s3_res_ff, s3_res_in;
   logic              s3_neg_re_ff, s3_neg_im_ff;
   abs_type           s3_abs_re_ff, s3_abs_re_in, s3_abs_im_ff, s3_abs_im_in;
   umag_type          s3_d_ff;

   // divider: entry 0 is loaded from stage 3, one quotient bit per entry after
   logic      dv_valid_ff [cau_pkg::DIV_STAGES+1];
   carry_type dv_carry_ff [cau_pkg::DIV_STAGES+1];
   carry_type dv_carry_in [cau_pkg::DIV_STAGES+1];
   rem_type   dv_rem_ff   [cau_pkg::DIV_STAGES+1][2];
   rem_type   dv_rem_in   [cau_pkg::DIV_STAGES+1][2];
   quot_type  dv_nq_ff    [cau_pkg::DIV_STAGES+1][2];
   quot_type  dv_nq_in    [cau_pkg::DIV_STAGES+1][2];

   logic              out_valid_ff, out_valid_in;
   cau_pkg::res_type  out_res_ff, out_res_in;

   assign advance    = !out_valid_ff || rsp_ready;
   assign item_ready = advance;
   assign rsp_valid  = out_valid_ff;
   assign rsp_res    = out_res_ff;

   // stage 1
   always_comb begin
      wide_word_type sr, si;
      sat_type       qr, qi;
      s1_res_in = '0;
      if (item.kind == cau_pkg::KIND_SUB) begin
         sr = wide_word_type'(item.a_real) - wide_word_type'(item.b_real);
         si = wide_word_type'(item.a_imag) - wide_word_type'(item.b_imag);
      end else begin
         sr = wide_word_type'(item.a_real) + wide_word_type'(item.b_real);
         si = wide_word_type'(item.a_imag) + wide_word_type'(item.b_imag);
      end
      qr = sat_sum(sr);
      qi = sat_sum(si);
      if (item.kind == cau_pkg::KIND_ADD || item.kind == cau_pkg::KIND_SUB) begin
         s1_res_in.re  = qr.value;
         s1_res_in.im  = qi.value;
         s1_res_in.ovf = qr.ovf | qi.ovf;
      end
      if (item.kind == cau_pkg::KIND_TRUTH) begin
         s1_res_in.truth = item.truth;
      end
   end

   // stage 2
   always_comb begin
      if (s1_kind_ff == cau_pkg::KIND_MUL) begin
         s2_re_in = sum_type'(s1_rr_ff) - sum_type'(s1_ii_ff);
         s2_im_in = sum_type'(s1_ri_ff) + sum_type'(s1_ir_ff);
      end else begin
         s2_re_in = sum_type'(s1_rr_ff) + sum_type'(s1_ii_ff);
         s2_im_in = sum_type'(s1_ir_ff) - sum_type'(s1_ri_ff);
      end
   end

   // stage 3
   always_comb begin
      s3_abs_re_in = s2_re_ff[cau_pkg::SUM_W-1] ? abs_type'(-s2_re_ff) : abs_type'(s2_re_ff);
      s3_abs_im_in = s2_im_ff[cau_pkg::SUM_W-1] ? abs_type'(-s2_im_ff) : abs_type'(s2_im_ff);
      s3_res_in    = s2_res_ff;
      if (s2_kind_ff == cau_pkg::KIND_MAG) begin
         case (s2_rel_ff)
            cau_pkg::REL_LT: s3_res_in.truth = s2_ma_ff < s2_mb_ff;
            cau_pkg::REL_GT: s3_res_in.truth = s2_ma_ff > s2_mb_ff;
            cau_pkg::REL_LE: s3_res_in.truth = s2_ma_ff <= s2_mb_ff;
            cau_pkg::REL_GE: s3_res_in.truth = s2_ma_ff >= s2_mb_ff;
            default:         s3_res_in.truth = 1'b0;
         endcase
      end
      if (s2_kind_ff == cau_pkg::KIND_DIV && s2_mb_ff == '0) begin
         s3_res_in.zdiv = 1'b1;
      end
   end

   // entry 0: scale dividend, check quotient range, finish multiply;
   // then one restoring step per entry, real and imaginary lanes side by side
   always_comb begin
      num_type                 nre, nim;
      sat_type                 mr, mi;
      logic [cau_pkg::REM_W:0] rw, df;
      logic                    ge;
      nre = num_type'(s3_abs_re_ff[cau_pkg::PROD_W-1:0]) << cau_pkg::FRAC_BITS;
      nim = num_type'(s3_abs_im_ff[cau_pkg::PROD_W-1:0]) << cau_pkg::FRAC_BITS;
      mr  = sat_mag(s3_neg_re_ff, s3_abs_re_ff >> cau_pkg::FRAC_BITS);
      mi  = sat_mag(s3_neg_im_ff, s3_abs_im_ff >> cau_pkg::FRAC_BITS);
      dv_carry_in[0].kind   = s3_kind_ff;
      dv_carry_in[0].res    = s3_res_ff;
      dv_carry_in[0].neg_re = s3_neg_re_ff;
      dv_carry_in[0].neg_im = s3_neg_im_ff;
      dv_carry_in[0].d      = s3_d_ff;
      dv_carry_in[0].head_re = rem_type'(nre[cau_pkg::NUM_W-1:cau_pkg::QUOT_W])
                               >= rem_type'(s3_d_ff);
      dv_carry_in[0].head_im = rem_type'(nim[cau_pkg::NUM_W-1:cau_pkg::QUOT_W])
                               >= rem_type'(s3_d_ff);
      dv_rem_in[0][0] = rem_type'(nre[cau_pkg::NUM_W-1:cau_pkg::QUOT_W]);
      dv_rem_in[0][1] = rem_type'(nim[cau_pkg::NUM_W-1:cau_pkg::QUOT_W]);
      dv_nq_in[0][0]  = nre[cau_pkg::QUOT_W-1:0];
      dv_nq_in[0][1]  = nim[cau_pkg::QUOT_W-1:0];
      if (s3_kind_ff == cau_pkg::KIND_MUL) begin
         dv_carry_in[0].res.re  = mr.value;
         dv_carry_in[0].res.im  = mi.value;
         dv_carry_in[0].res.ovf = mr.ovf | mi.ovf;
      end
      for (int k = 0; k < cau_pkg::DIV_STAGES; k++) begin
         dv_carry_in[k+1] = dv_carry_ff[k];
         for (int l = 0; l < 2; l++) begin
            rw = {dv_rem_ff[k][l], dv_nq_ff[k][l][cau_pkg::QUOT_W-1]};
            df = rw - (cau_pkg::REM_W+1)'(dv_carry_ff[k].d);
            ge = rw >= (cau_pkg::REM_W+1)'(dv_carry_ff[k].d);
            dv_rem_in[k+1][l] = ge ? df[cau_pkg::REM_W-1:0] : rw[cau_pkg::REM_W-1:0];
            dv_nq_in[k+1][l]  = {dv_nq_ff[k][l][cau_pkg::QUOT_W-2:0], ge};
         end
      end
   end

   // final saturation of quotients
   always_comb begin
      carry_type c;
      sat_type   qr, qi;
      c  = dv_carry_ff[cau_pkg::DIV_STAGES];
      qr = sat_mag(c.neg_re, abs_type'(dv_nq_ff[cau_pkg::DIV_STAGES][0]));
      qi = sat_mag(c.neg_im, abs_type'(dv_nq_ff[cau_pkg::DIV_STAGES][1]));
      if (c.head_re) begin
         qr.ovf   = 1'b1;
         qr.value = c.neg_re ? cau_pkg::WORD_MIN : cau_pkg::WORD_MAX;
      end
      if (c.head_im) begin
         qi.ovf   = 1'b1;
         qi.value = c.neg_im ? cau_pkg::WORD_MIN : cau_pkg::WORD_MAX;
      end
      out_res_in = c.res;
      if (c.kind == cau_pkg::KIND_DIV && !c.res.zdiv) begin
         out_res_in.re  = qr.value;
         out_res_in.im  = qi.value;
         out_res_in.ovf = qr.ovf | qi.ovf;
      end
      out_valid_in = advance ? dv_valid_ff[cau_pkg::DIV_STAGES] : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k <= cau_pkg::DIV_STAGES; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            s1_valid_ff    <= item_valid;
            s2_valid_ff    <= s1_valid_ff;
            s3_valid_ff    <= s2_valid_ff;
            dv_valid_ff[0] <= s3_valid_ff;
            for (int k = 0; k < cau_pkg::DIV_STAGES; k++) begin
               dv_valid_ff[k+1] <= dv_valid_ff[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_kind_ff   <= item.kind;
         s1_rel_ff    <= item.rel;
         s1_res_ff    <= s1_res_in;
         s1_rr_ff     <= item.a_real * item.b_real;
         s1_ii_ff     <= item.a_imag * item.b_imag;
         s1_ri_ff     <= item.a_real * item.b_imag;
         s1_ir_ff     <= item.a_imag * item.b_real;
         s1_sar_ff    <= item.a_real * item.a_real;
         s1_sai_ff    <= item.a_imag * item.a_imag;
         s1_sbr_ff    <= item.b_real * item.b_real;
         s1_sbi_ff    <= item.b_imag * item.b_imag;
         s2_kind_ff   <= s1_kind_ff;
         s2_rel_ff    <= s1_rel_ff;
         s2_res_ff    <= s1_res_ff;
         s2_re_ff     <= s2_re_in;
         s2_im_ff     <= s2_im_in;
         s2_ma_ff     <= umag_type'(s1_sar_ff) + umag_type'(s1_sai_ff);
         s2_mb_ff     <= umag_type'(s1_sbr_ff) + umag_type'(s1_sbi_ff);
         s3_kind_ff   <= s2_kind_ff;
         s3_res_ff    <= s3_res_in;
         s3_neg_re_ff <= s2_re_ff[cau_pkg::SUM_W-1];
         s3_neg_im_ff <= s2_im_ff[cau_pkg::SUM_W-1];
         s3_abs_re_ff <= s3_abs_re_in;
         s3_abs_im_ff <= s3_abs_im_in;
         s3_d_ff      <= s2_mb_ff;
         for (int k = 0; k <= cau_pkg::DIV_STAGES; k++) begin
            dv_carry_ff[k]  <= dv_carry_in[k];
            dv_rem_ff[k][0] <= dv_rem_in[k][0];
            dv_rem_ff[k][1] <= dv_rem_in[k][1];
            dv_nq_ff[k][0]  <= dv_nq_in[k][0];
            dv_nq_ff[k][1]  <= dv_nq_in[k][1];
         end
         out_res_ff   <= out_res_in;
      end
   end

   `CAU_ASSERT(a_zdiv_clean, clock, reset, out_valid_ff && out_res_ff.zdiv |-> !out_res_ff.ovf && out_res_ff.re == '0 && out_res_ff.im == '0 && !out_res_ff.truth)
   `CAU_ASSERT(a_ovf_bound, clock, reset, out_valid_ff && out_res_ff.ovf |-> out_res_ff.re == cau_pkg::WORD_MAX || out_res_ff.re == cau_pkg::WORD_MIN || out_res_ff.im == cau_pkg::WORD_MAX || out_res_ff.im == cau_pkg::WORD_MIN)
   `CAU_ASSERT_NEXT(a_out_hold, clock, reset, out_valid_ff && !rsp_ready, out_valid_ff && $stable(out_res_ff))

endmodule

/* hdl/complex_arithmetic_unit.sv */
// Top level of the complex arithmetic unit: front, queue and back.
//
//  channel  dir  beat contents (low bits first)
//  req_     in   tuser: action; tdata: a_real, a_imag, b_real, b_imag
//  rsp_     out  tuser: truth, zero_divisor, overflow; tdata: res_real, res_imag
//
// One beat in and one beat out per cycle when both sides flow.
// After its request beat enters the input register, a result passes in order through the
// queue, three arithmetic stages, a scaling stage, 33 restoring divide stages,
// output register. The divide pipeline sets the latency; every action takes it.
// Synchronous active-high reset clears valid and queue state only.
// A stalled rsp_ freezes the back end; the queue and input register absorb
// up to three more request beats before req_tready drops.
module complex_arithmetic_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // a_real, a_imag, b_real, b_imag
   input  logic [cau_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action
   input  logic [cau_pkg::ACTION_W-1:0]     req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // res_real, res_imag
   output logic [cau_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // truth, zero_divisor, overflow
   output logic [cau_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   localparam int DW = cau_pkg::DATA_WIDTH;

   cau_pkg::item_type front_item, back_item;
   logic              front_valid, front_ready;
   logic              back_valid, back_ready;
   cau_pkg::res_type  res;

   cau_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .req_a_real (req_tdata[DW-1:0]),
      .req_a_imag (req_tdata[2*DW-1:DW]),
      .req_b_real (req_tdata[3*DW-1:2*DW]),
      .req_b_imag (req_tdata[4*DW-1:3*DW]),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item       (front_item)
   );

   cau_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_item  (back_item)
   );

   cau_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .item       (back_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_res    (res)
   );

   assign rsp_tdata = cau_pkg::RSP_DATA_W'({res.im, res.re});
   assign rsp_tuser = {res.ovf, res.zdiv, res.truth};

endmodule

/* test/cau_checker.sv */
// Checker for the complex arithmetic unit: predicts each result and compares beats.
module cau_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [cau_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [cau_pkg::ACTION_W-1:0]     req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [cau_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic [cau_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output int                               errors,
   output int                               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = cau_pkg::DATA_WIDTH;

   cau_pkg::res_type expected_q[$];

   localparam longint LMAX = (64'sd1 <<< (DW - 1)) - 1;
   localparam longint LMIN = -(64'sd1 <<< (DW - 1));

   // clamp a wide signed value to the word range
   function automatic cau_pkg::word_type clamp(input logic signed [127:0] v,
                                               inout logic ovf);
      if (v > LMAX) begin
         ovf = 1'b1;
         return cau_pkg::WORD_MAX;
      end
      if (v < LMIN) begin
         ovf = 1'b1;
         return cau_pkg::WORD_MIN;
      end
      return cau_pkg::word_type'(v);
   endfunction

   // truncating division toward zero of a scaled signed numerator
   function automatic logic signed [127:0] quot_trunc(input logic signed [127:0] num,
                                                      input logic signed [127:0] den);
      logic signed [127:0] mag;
      mag = ((num < 0) ? -num : num) <<< cau_pkg::FRAC_BITS;
      mag = mag / den;
      return (num < 0) ? -mag : mag;
   endfunction

   function automatic cau_pkg::res_type predict_result(input cau_pkg::action_type act,
                                                       input cau_pkg::word_type ar,
                                                       input cau_pkg::word_type ai,
                                                       input cau_pkg::word_type br,
                                                       input cau_pkg::word_type bi);
      cau_pkg::res_type r;
      logic signed [127:0] xr, xi, yr, yi, pr, pi, ma, mb;
      logic ovf;
      r = '0;
      ovf = 1'b0;
      xr = ar; xi = ai; yr = br; yi = bi;
      ma = xr * xr + xi * xi;
      mb = yr * yr + yi * yi;
      case (act)
         cau_pkg::ACT_ADD: begin
            r.re = clamp(xr + yr, ovf);
            r.im = clamp(xi + yi, ovf);
         end
         cau_pkg::ACT_SUB: begin
            r.re = clamp(xr - yr, ovf);
            r.im = clamp(xi - yi, ovf);
         end
         cau_pkg::ACT_MUL: begin
            // shift of magnitude: truncation toward zero
            pr = xr * yr - xi * yi;
            pi = xr * yi + xi * yr;
            pr = (pr < 0) ? -((-pr) >>> cau_pkg::FRAC_BITS) : (pr >>> cau_pkg::FRAC_BITS);
            pi = (pi < 0) ? -((-pi) >>> cau_pkg::FRAC_BITS) : (pi >>> cau_pkg::FRAC_BITS);
            r.re = clamp(pr, ovf);
            r.im = clamp(pi, ovf);
         end
         cau_pkg::ACT_DIV: begin
            if (mb == 0) begin
               r.zdiv = 1'b1;
            end else begin
               r.re = clamp(quot_trunc(xr * yr + xi * yi, mb), ovf);
               r.im = clamp(quot_trunc(yr * xi - xr * yi, mb), ovf);
            end
         end
         cau_pkg::ACT_EQ: r.truth = (ar == br) && (ai == bi);
         cau_pkg::ACT_NE: r.truth = (ar != br) || (ai != bi);
         cau_pkg::ACT_LT: r.truth = ma < mb;
         cau_pkg::ACT_GT: r.truth = ma > mb;
         cau_pkg::ACT_LE: r.truth = ma <= mb;
         cau_pkg::ACT_GE: r.truth = ma >= mb;
         default: ;
      endcase
      r.ovf = ovf;
      return r;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      errors++;
   endtask

   initial begin
      errors  = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      cau_pkg::res_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_q = {expected_q, predict_result(req_tuser,
               req_tdata[DW-1:0], req_tdata[2*DW-1:DW],
               req_tdata[3*DW-1:2*DW], req_tdata[4*DW-1:3*DW])};
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               report("unexpected beat", rsp_tdata, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata[DW-1:0] !== want.re)
                  report("res_real", rsp_tdata[DW-1:0], want.re);
               if (rsp_tdata[2*DW-1:DW] !== want.im)
                  report("res_imag", rsp_tdata[2*DW-1:DW], want.im);
               if (rsp_tuser[0] !== want.truth) report("truth", rsp_tuser[0], want.truth);
               if (rsp_tuser[1] !== want.zdiv) report("zero_divisor", rsp_tuser[1], want.zdiv);
               if (rsp_tuser[2] !== want.ovf) report("overflow", rsp_tuser[2], want.ovf);
            end
         end
      end
      pending <= expected_q.size();
   end

endmodule

/* test/tb.sv */
// Testbench top for the complex arithmetic unit: stimulus, watchdog and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BEATS = 1500;
   localparam int STALL_LIMIT  = 2000;   // idle cycles before the run is declared hung
   localparam int DRAIN_CYCLES = 60;     // beyond the pipeline latency

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [cau_pkg::REQ_DATA_W-1:0]   req_tdata = '0;    // a_real, a_imag, b_real, b_imag
   logic [cau_pkg::ACTION_W-1:0]     req_tuser = '0;    // action
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [cau_pkg::RSP_DATA_W-1:0]   rsp_tdata;         // res_real, res_imag
   logic [cau_pkg::RSP_USER_W-1:0]   rsp_tuser;         // truth, zero_divisor, overflow
   int                               errors;
   int                               pending;
   int                               idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   complex_arithmetic_unit dut (.*);

   cau_checker checker_i (.*);

   // pick an interesting operand part: extremes, small values, or fully random
   function automatic cau_pkg::word_type pick_word();
      case ($urandom_range(0, 9))
         0: return cau_pkg::WORD_MAX;
         1: return cau_pkg::WORD_MIN;
         2: return '0;
         3: return cau_pkg::word_type'($urandom_range(0, 8) << cau_pkg::FRAC_BITS);
         4: return -cau_pkg::word_type'($urandom_range(0, 8) << cau_pkg::FRAC_BITS);
         5: return cau_pkg::word_type'($signed($urandom_range(0, 65535)) - 32768);
         default: return cau_pkg::word_type'($urandom);
      endcase
   endfunction

   // drive one beat and hold it until accepted; valid drops only during a gap
   task automatic send_beat(input cau_pkg::action_type act,
                            input cau_pkg::word_type ar, input cau_pkg::word_type ai,
                            input cau_pkg::word_type br, input cau_pkg::word_type bi);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {bi, br, ai, ar};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // receiver: random stall before each beat, with streaks of no stalls
   initial begin
      int wait_n;
      @(negedge reset);
      forever begin
         wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (wait_n != 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      cau_pkg::word_type   a, b;
      cau_pkg::action_type act;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every action incl. unused codes, extremes, zero divisor, saturation
      for (int k = 0; k < 16; k++)
         send_beat(cau_pkg::action_type'(k), cau_pkg::WORD_MAX, cau_pkg::WORD_MIN,
                   cau_pkg::WORD_MIN, cau_pkg::WORD_MAX);
      send_beat(cau_pkg::ACT_DIV, 32'sh0001_0000, 32'sh0002_0000, '0, '0);  // zero divisor
      send_beat(cau_pkg::ACT_DIV, cau_pkg::WORD_MAX, cau_pkg::WORD_MAX,
                32'sh0000_0001, '0);                                       // quotient saturates
      send_beat(cau_pkg::ACT_MUL, cau_pkg::WORD_MIN, cau_pkg::WORD_MIN,
                cau_pkg::WORD_MIN, cau_pkg::WORD_MIN);                     // product saturates
      send_beat(cau_pkg::ACT_ADD, cau_pkg::WORD_MIN, cau_pkg::WORD_MIN,
                cau_pkg::WORD_MIN, cau_pkg::WORD_MIN);                     // sum saturates low
      send_beat(cau_pkg::ACT_SUB, cau_pkg::WORD_MAX, cau_pkg::WORD_MIN,
                cau_pkg::WORD_MIN, cau_pkg::WORD_MAX);
      send_beat(cau_pkg::ACT_EQ, 32'sh0003_0000, -32'sh1, 32'sh0003_0000, -32'sh1);
      send_beat(cau_pkg::ACT_LE, 32'sh0003_0000, 32'sh0004_0000,
                32'sh0005_0000, '0);                                       // equal magnitudes
      send_beat(cau_pkg::ACT_GE, 32'sh0004_0000, 32'sh0003_0000, '0, -32'sh0005_0000);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         act = ($urandom_range(0, 19) == 0) ? cau_pkg::action_type'($urandom_range(10, 15))
                                            : cau_pkg::action_type'($urandom_range(0, 9));
         a = pick_word();
         b = pick_word();
         // equal operands now and then so equality and magnitude ties show up
         if ($urandom_range(0, 5) == 0)
            send_beat(act, a, b, a, b);
         else if ($urandom_range(0, 9) == 0)
            send_beat(act, a, b, '0, '0);
         else
            send_beat(act, a, b, pick_word(), pick_word());
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
